### rtl/core/tus_pkg.sv
// Package for the triangle uniform subdivider: sizes, types and constants.
// No dependencies; every module of the block imports it.
package tus_pkg;

   localparam int MaxDiv    = 8;
   localparam int CoordW    = 32;
   localparam int DivW      = 4;
   localparam int RowW      = 4;
   localparam int PtW       = 6;
   localparam int NumPts    = (MaxDiv + 1) * (MaxDiv + 2) / 2;
   localparam int NumDenoms = MaxDiv;
   localparam int LenW      = 27;
   localparam int PerW      = 29;

   localparam logic [LenW-1:0] LenCap   = 27'd67108864;
   localparam logic [PerW-1:0] AutoBias = 29'd2621440;   // 40 in Q16.16
   localparam logic [PerW-1:0] AutoStep = 29'd5242880;   // 80 in Q16.16

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_AUTO,
      ST_LAT,
      ST_EMIT
   } state_type;

   // Index of lattice point (i, j) in row-major order of a count-n lattice.
   function automatic logic [PtW-1:0] pt_index(input logic [RowW-1:0] i,
                                               input logic [RowW-1:0] j,
                                               input logic [RowW-1:0] n);
      logic [PtW+2:0] base;
      base = ({5'd0, i} * ({5'd0, n} + 9'd2) * 9'd2 - {5'd0, i} - {5'd0, i} * {5'd0, i})
             >> 1;
      return PtW'(base + {5'd0, j});
   endfunction

endpackage

### rtl/core/triangle_uniform_subdivider.sv
// Top level of the triangle uniform subdivider: sequencer, lattice memory
// and output register. Depends on tus_pkg, tus_divider and tus_sqrt.
//
//  channel | direction | payload
//  req     | in        | tdata: divisions, ax..cz (296 bits)
//  rsp     | out       | tdata: p0x..p2z (288 bits); tlast: last_piece
//
// One triangle at a time. Lattice setup runs every coordinate quotient through
// the shared divider, and automatic mode first takes the edge square roots.
// Emission reads the lattice memory one vertex a cycle while the output register
// is free, pausing as each sub-triangle loads into it. A stalled rsp
// holds the output register. Reset returns the sequencer to idle; no clearing pass.
module triangle_uniform_subdivider (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [295:0] req_tdata,   // divisions[3:0], ax, ay, az, bx, by_coord,
                                     // bz, cx, cy, cz, 4 zero bits at the top
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z
   output logic         rsp_tlast    // last_piece
);
   import tus_pkg::*;

   state_type st_ff, st_in;

   coord_type  cor_ff [9];
   logic [RowW-1:0] n_ff, n_in;
   logic [DivW-1:0] dreq;

   // Lattice memory: one entry per lattice point, xyz packed.
   point_type  lat_mem [NumPts];
   point_type  lat_rd_ff;
   logic [PtW-1:0] rd_addr;
   logic        wr_en;
   logic [PtW-1:0] wr_addr;
   point_type  wr_data;

   // Setup loop counters: coordinate k, row i, column j, phase.
   logic [1:0]      k_ff, k_in;
   logic [RowW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]      ph_ff, ph_in;
   logic            go_ff, go_in;
   coord_type       beg_ff, beg_in, end_ff, end_in;
   point_type       pt_ff, pt_in;

   // Divider hookup.
   logic               dv_start;
   logic signed [39:0] dv_num;
   logic [RowW-1:0]    dv_den;
   logic               dv_done;
   logic signed [39:0] dv_q;

   // Square-root hookup for automatic mode.
   logic               sq_start;
   logic [55:0]        sq_rad;
   logic               sq_done;
   logic [27:0]        sq_root;
   logic [1:0]         e_ff, e_in;
   logic [PerW-1:0]    per_ff, per_in;
   logic [55:0]        ssum_ff, ssum_in;
   logic [1:0]         sc_ff, sc_in;
   logic               cap_ff, cap_in;

   // Emission counters.
   logic [RowW-1:0] ei_ff, ei_in, ej_ff, ej_in;
   logic            pass_ff, pass_in;
   logic [1:0]      v_ff, v_in;
   logic            rdv_ff;
   logic [1:0]      rdvi_ff;
   point_type       tri_ff [3];
   logic [6:0]      cnt_ff, cnt_in;

   logic            ov_ff, ov_in;
   logic [287:0]    od_ff;
   logic            ol_ff;
   logic            olast_in;
   logic            load_out;

   logic [RowW-1:0] vi, vj;
   coord_type       ca, cb, cc;
   logic signed [33:0] da, db, dd;
   logic signed [31:0] sa, sb;
   logic [31:0]     ma;
   logic [63:0]     msq;

   tus_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .numer(dv_num),
      .denom(dv_den), .done(dv_done), .quot(dv_q)
   );

   tus_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .done(sq_done), .root(sq_root)
   );

   assign dreq = req_tdata[3:0];

   // Corners of the current coordinate k.
   always_comb begin
      ca = cor_ff[{2'd0, k_ff}];
      cb = cor_ff[4'd3 + {2'd0, k_ff}];
      cc = cor_ff[4'd6 + {2'd0, k_ff}];
   end

   // Edge components for automatic mode: edge e, component sc.
   always_comb begin
      unique case (e_ff)
         2'd0: begin
            sa = cor_ff[{2'd0, sc_ff}];
            sb = cor_ff[4'd3 + {2'd0, sc_ff}];
         end
         2'd1: begin
            sa = cor_ff[4'd3 + {2'd0, sc_ff}];
            sb = cor_ff[4'd6 + {2'd0, sc_ff}];
         end
         default: begin
            sa = cor_ff[4'd6 + {2'd0, sc_ff}];
            sb = cor_ff[{2'd0, sc_ff}];
         end
      endcase
      dd  = 34'(sb) - 34'(sa);
      ma  = dd[33] ? 32'(-dd) : 32'(dd);
      msq = {32'd0, ma} * {32'd0, ma};
   end

   // Vertex selection for emission.
   always_comb begin
      vi = ei_ff;
      vj = ej_ff;
      unique case ({pass_ff, v_ff})
         3'b000:  begin vi = ei_ff;        vj = ej_ff;        end
         3'b001:  begin vi = ei_ff;        vj = ej_ff + 4'd1; end
         3'b010:  begin vi = ei_ff + 4'd1; vj = ej_ff;        end
         3'b100:  begin vi = ei_ff;        vj = ej_ff + 4'd1; end
         3'b101:  begin vi = ei_ff + 4'd1; vj = ej_ff;        end
         default: begin vi = ei_ff + 4'd1; vj = ej_ff + 4'd1; end
      endcase
      rd_addr = pt_index(vi, vj, n_ff);
   end

   // Sequencer.
   always_comb begin
      st_in    = st_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      ph_in    = ph_ff;
      go_in    = 1'b0;
      beg_in   = beg_ff;
      end_in   = end_ff;
      pt_in    = pt_ff;
      e_in     = e_ff;
      per_in   = per_ff;
      ssum_in  = ssum_ff;
      sc_in    = sc_ff;
      cap_in   = cap_ff;
      ei_in    = ei_ff;
      ej_in    = ej_ff;
      pass_in  = pass_ff;
      v_in     = v_ff;
      cnt_in   = cnt_ff;
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = n_ff;
      sq_start = 1'b0;
      sq_rad   = ssum_ff;
      wr_en    = 1'b0;
      wr_addr  = pt_index(i_ff, j_ff, n_ff);
      wr_data  = pt_ff;
      req_tready = 1'b0;
      da = '0;
      db = '0;
      unique case (st_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               e_in    = 2'd0;
               sc_in   = 2'd0;
               ssum_in = '0;
               cap_in  = 1'b0;
               per_in  = '0;
               if (dreq == 4'd0) begin
                  st_in = ST_SQ;
               end else begin
                  n_in  = (dreq > 4'(MaxDiv)) ? 4'(MaxDiv) : dreq;
                  st_in = ST_LAT;
                  k_in  = 2'd0;
                  i_in  = 4'd0;
                  j_in  = 4'd0;
                  ph_in = 2'd0;
                  go_in = 1'b1;
               end
            end
         end
         ST_SQ: begin
            // One squared component per cycle.
            if (ma >= 32'(LenCap)) cap_in = 1'b1;
            ssum_in = ssum_ff + msq[55:0];
            sc_in   = sc_ff + 2'd1;
            if (sc_ff == 2'd2) begin
               sc_in = 2'd0;
               st_in = ST_SQRT;
               sq_start = 1'b1;
               sq_rad   = ssum_ff + msq[55:0];
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               per_in  = per_ff + (cap_ff ? PerW'(LenCap) : PerW'(sq_root));
               ssum_in = '0;
               cap_in  = 1'b0;
               e_in    = e_ff + 2'd1;
               st_in   = (e_ff == 2'd2) ? ST_AUTO : ST_SQ;
            end
         end
         ST_AUTO: begin
            // Compare in place of a division: k = floor((P+40)/80), clamped to 2..8.
            n_in = 4'(MaxDiv);
            for (int t = MaxDiv; t >= 2; t--) begin
               if ((per_ff + AutoBias) < PerW'(t) * AutoStep) n_in = 4'(t - 1);
            end
            if (n_in < 4'd2) n_in = 4'd2;
            st_in = ST_LAT;
            k_in  = 2'd0;
            i_in  = 4'd0;
            j_in  = 4'd0;
            ph_in = 2'd0;
            go_in = 1'b1;
         end
         ST_LAT: begin
            // Phases: row begin, row end, then each point of the row.
            da = 34'(cc) - 34'(ca);
            db = 34'(cc) - 34'(cb);
            unique case (ph_ff)
               2'd0: begin
                  dv_num = 40'(da) * 40'(i_ff);
                  dv_den = n_ff;
               end
               2'd1: begin
                  dv_num = 40'(db) * 40'(i_ff);
                  dv_den = n_ff;
               end
               default: begin
                  dv_num = 40'(34'(end_ff) - 34'(beg_ff)) * 40'(j_ff);
                  dv_den = n_ff - i_ff;
               end
            endcase
            if (i_ff == n_ff) begin
               // Apex row holds only corner c.
               if (go_ff || ph_ff != 2'd3) begin
                  ph_in = 2'd3;
                  unique case (k_ff)
                     2'd0:    pt_in.x = cc;
                     2'd1:    pt_in.y = cc;
                     default: pt_in.z = cc;
                  endcase
               end else begin
                  wr_en = 1'b1;
                  if (k_ff == 2'd2) begin
                     st_in = ST_EMIT;
                     ei_in = 4'd0;
                     ej_in = 4'd0;
                     pass_in = 1'b0;
                     v_in  = 2'd0;
                     cnt_in = '0;
                  end else begin
                     k_in  = k_ff + 2'd1;
                     i_in  = 4'd0;
                     j_in  = 4'd0;
                     ph_in = 2'd0;
                     go_in = 1'b1;
                  end
               end
            end else begin
               dv_start = go_ff;
               if (dv_done) begin
                  go_in = 1'b1;
                  unique case (ph_ff)
                     2'd0: begin
                        beg_in = ca + 32'(dv_q);
                        ph_in  = 2'd1;
                     end
                     2'd1: begin
                        end_in = cb + 32'(dv_q);
                        ph_in  = 2'd2;
                     end
                     default: begin
                        // Only the lane of coordinate k is written into the entry.
                        unique case (k_ff)
                           2'd0:    pt_in.x = beg_ff + 32'(dv_q);
                           2'd1:    pt_in.y = beg_ff + 32'(dv_q);
                           default: pt_in.z = beg_ff + 32'(dv_q);
                        endcase
                        wr_en   = 1'b1;
                        wr_data = pt_in;
                        if (j_ff == n_ff - i_ff) begin
                           j_in  = 4'd0;
                           i_in  = i_ff + 4'd1;
                           ph_in = 2'd0;
                        end else begin
                           j_in = j_ff + 4'd1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_EMIT: begin
            // One vertex read a cycle; wait for a free output register and for each load into it.
            if (!(ov_ff && !rsp_tready) && !(rdv_ff && rdvi_ff == 2'd2)) begin
               if (v_ff == 2'd2) begin
                  v_in = 2'd0;
               end else begin
                  v_in = v_ff + 2'd1;
               end
            end
            if (load_out) begin
               cnt_in = cnt_ff + 7'd1;
               if (!pass_ff && ej_ff != n_ff - ei_ff - 4'd1) begin
                  pass_in = 1'b1;
               end else begin
                  pass_in = 1'b0;
                  if (ej_ff == n_ff - ei_ff - 4'd1) begin
                     ej_in = 4'd0;
                     ei_in = ei_ff + 4'd1;
                  end else begin
                     ej_in = ej_ff + 4'd1;
                  end
               end
               if (olast_in) st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Output register loads when the third vertex read returns.
   assign load_out = (st_ff == ST_EMIT) && rdv_ff && (rdvi_ff == 2'd2);
   assign olast_in = (cnt_ff + 7'd1) == 7'(n_ff) * 7'(n_ff);

   always_comb begin
      ov_in = ov_ff;
      if (rsp_tready) ov_in = 1'b0;
      if (load_out)   ov_in = 1'b1;
   end

   // Lattice memory: one write port with a lane per coordinate, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         unique case (k_ff)
            2'd0:    lat_mem[wr_addr].x <= wr_data.x;
            2'd1:    lat_mem[wr_addr].y <= wr_data.y;
            default: lat_mem[wr_addr].z <= wr_data.z;
         endcase
      end
      lat_rd_ff <= lat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         ov_ff  <= 1'b0;
         rdv_ff <= 1'b0;
         go_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         ov_ff  <= ov_in;
         rdv_ff <= (st_ff == ST_EMIT) && !(ov_ff && !rsp_tready) &&
                   !(rdv_ff && rdvi_ff == 2'd2) && !load_out;
         go_ff  <= go_in;
      end
      rdvi_ff <= v_ff;
      if (st_ff == ST_IDLE && req_tvalid) begin
         for (int t = 0; t < 9; t++) cor_ff[t] <= req_tdata[4 + 32*t +: 32];
      end
      n_ff <= n_in; k_ff <= k_in; i_ff <= i_in; j_ff <= j_in; ph_ff <= ph_in;
      beg_ff <= beg_in; end_ff <= end_in; pt_ff <= pt_in;
      e_ff <= e_in; per_ff <= per_in; ssum_ff <= ssum_in; sc_ff <= sc_in;
      cap_ff <= cap_in;
      ei_ff <= ei_in; ej_ff <= ej_in; pass_ff <= pass_in; v_ff <= v_in;
      cnt_ff <= cnt_in;
      if (rdv_ff) tri_ff[rdvi_ff] <= lat_rd_ff;
      if (load_out) begin
         od_ff <= {lat_rd_ff, tri_ff[1], tri_ff[0]} ;
         ol_ff <= olast_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = ol_ff;
   // Reorder packed xyz so x sits lowest within each vertex.
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         rsp_tdata[96*t +: 32]      = od_ff[96*t + 64 +: 32];
         rsp_tdata[96*t + 32 +: 32] = od_ff[96*t + 32 +: 32];
         rsp_tdata[96*t + 64 +: 32] = od_ff[96*t +: 32];
      end
   end
endmodule

### rtl/core/tus_divider.sv
// Iterative signed divider, rounding to nearest with ties away from zero.
// Depends on tus_pkg; one quotient bit per cycle.
module tus_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [39:0]        numer,
   input  logic [tus_pkg::RowW-1:0]  denom,
   output logic                      done,
   output logic signed [39:0]        quot
);
   import tus_pkg::*;

   logic [40:0] rem_ff, rem_in;
   logic [40:0] num_ff, num_in;
   logic [39:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  den_ff, den_in;
   logic [40:0] trial;
   logic [40:0] mag;

   // Magnitude plus half the divisor, then restoring long division.
   always_comb begin
      mag     = numer[39] ? 41'(-{numer[39], numer}) : 41'({numer[39], numer});
      rem_in  = rem_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      trial   = {rem_ff[39:0], num_ff[40]} - 41'(den_ff);
      if (start) begin
         num_in  = mag + 41'(denom >> 1);
         rem_in  = '0;
         cnt_in  = 6'd41;
         neg_in  = numer[39];
         den_in  = denom;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[39:0], 1'b0};
         if (!trial[40]) begin
            rem_in = trial;
            q_in   = {q_ff[38:0], 1'b1};
         end else begin
            rem_in = {rem_ff[39:0], num_ff[40]};
            q_in   = {q_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
endmodule

### rtl/core/tus_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on tus_pkg; used for the edge lengths of automatic mode.
module tus_sqrt (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [55:0]     radicand,
   output logic            done,
   output logic [27:0]     root
);
   import tus_pkg::*;

   logic [55:0] v_ff, v_in;
   logic [27:0] r_ff, r_in;
   logic [57:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [57:0] sh;
   logic [57:0] trial;

   // Classic digit-by-digit root: bring down two bits, try 4r+1.
   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh      = {acc_ff[55:0], v_ff[55:54]};
      trial   = sh - {28'd0, r_ff, 2'b01};
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         acc_in  = '0;
         cnt_in  = 5'd28;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[53:0], 2'b00};
         if (!trial[57]) begin
            acc_in = trial;
            r_in   = {r_ff[26:0], 1'b1};
         end else begin
            acc_in = sh;
            r_in   = {r_ff[26:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign root = r_ff;
endmodule
